FILE: hw/rtl/sorted_alarm_queue_defines.svh
// Assertion macros for the sorted alarm queue
`ifndef SORTED_ALARM_QUEUE_DEFINES_SVH
`define SORTED_ALARM_QUEUE_DEFINES_SVH

// Same-cycle implication
`define SAQ_AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted_alarm_queue: same-cycle check failed");

// Next-cycle implication
`define SAQ_AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted_alarm_queue: next-cycle check failed");

`endif

FILE: hw/rtl/saq_pkg.sv
// Shared types, widths and codes of the sorted alarm queue
package saq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int AW          = $clog2(QUEUE_DEPTH);
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);
    localparam int PW          = AW + 1;
    localparam int WORD_W      = 64;
    localparam int ID_W        = 8;

    localparam logic [WORD_W-1:0] PREEMPT_TICKS_RST = WORD_W'(200000);

    localparam logic [1:0] KIND_SLEEP   = 2'd0;
    localparam logic [1:0] KIND_PREEMPT = 2'd1;
    localparam logic [1:0] KIND_EVENT   = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_PAST = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic {
        OP_ADD,
        OP_SUB
    } t_unit_op;

    typedef struct packed {
        logic [WORD_W-1:0] wake;
        logic [ID_W-1:0]   id;
        logic              pre;
    } t_entry;

endpackage

FILE: hw/rtl/saq_unit.sv
// Shared 64-bit adder: saturating add, or subtract whose carry shows a >= b
module saq_unit
    import saq_pkg::*;
(
    input  t_unit_op          i_op,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output logic [WORD_W-1:0] o_result,
    output logic              o_carry
);

    logic [WORD_W-1:0] b_op;
    logic [WORD_W:0]   sum;

    assign b_op     = (i_op == OP_SUB) ? ~i_b : i_b;
    assign sum      = {1'b0, i_a} + {1'b0, b_op} + (WORD_W + 1)'(i_op == OP_SUB);
    assign o_carry  = sum[WORD_W];
    assign o_result = (i_op == OP_ADD && sum[WORD_W]) ? '1 : sum[WORD_W-1:0];

endmodule

FILE: hw/rtl/saq_store.sv
// Entry store: one write port, one registered read port
module saq_store
    import saq_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/sorted_alarm_queue.sv
// Top level: sequencer of the sorted alarm queue around the shared adder and entry store
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------------
//  request   | start, busy            | i_kind, i_alarm_id, i_base_time, i_tick_count,
//            |                        | i_now, i_from_user_mode
//  result    | o_strobe               | o_expired_id, o_expired_valid, o_expired_preempt,
//            |                        | o_status, o_wake_time, o_compare_value,
//            |                        | o_timer_irq_enable, o_yield_request, o_last
//  config    | i_cfg_we               | i_cfg_wdata (preempt ticks)
//
// A request ends early when its wake time is past or the queue is full; else it moves each
// equal or later entry one place back and writes the new one ahead of them; the steps share
// the one adder and the single read port of the entry store.
// A timer event scans the expired entries until the queue is emptied or an entry is left,
// then emits one word per expired entry; an undefined kind answers at once.
// Reset is synchronous: count and enable cleared, compare register set to all ones;
// no clearing pass. The receiver cannot stall: each word shows for one cycle under o_strobe.
`include "sorted_alarm_queue_defines.svh"

module sorted_alarm_queue
    import saq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_kind,
    input  logic [ID_W-1:0]   i_alarm_id,
    input  logic [WORD_W-1:0] i_base_time,
    input  logic [WORD_W-1:0] i_tick_count,
    input  logic [WORD_W-1:0] i_now,
    input  logic              i_from_user_mode,
    input  logic              i_cfg_we,
    input  logic [WORD_W-1:0] i_cfg_wdata,
    output logic              o_strobe,
    output logic [ID_W-1:0]   o_expired_id,
    output logic              o_expired_valid,
    output logic              o_expired_preempt,
    output logic [1:0]        o_status,
    output logic [WORD_W-1:0] o_wake_time,
    output logic [WORD_W-1:0] o_compare_value,
    output logic              o_timer_irq_enable,
    output logic              o_yield_request,
    output logic              o_last
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WAKE  = 4'd1;
    localparam logic [3:0] S_PAST  = 4'd2;
    localparam logic [3:0] S_IRD   = 4'd3;
    localparam logic [3:0] S_ICMP  = 4'd4;
    localparam logic [3:0] S_ERD   = 4'd5;
    localparam logic [3:0] S_ECMP  = 4'd6;
    localparam logic [3:0] S_PRD   = 4'd7;
    localparam logic [3:0] S_PEMIT = 4'd8;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] ofs);
        logic [PW-1:0] s;
        s = {1'b0, head} + PW'(ofs);
        if (s >= PW'(QUEUE_DEPTH)) begin
            s = s - PW'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [3:0]        r_state, n_state;
    logic [1:0]        r_kind, n_kind;
    logic [ID_W-1:0]   r_id, n_id;
    logic [WORD_W-1:0] r_base, n_base;
    logic [WORD_W-1:0] r_cnt, n_cnt;
    logic [WORD_W-1:0] r_now, n_now;
    logic              r_user, n_user;
    logic [WORD_W-1:0] r_wake, n_wake;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_n, n_n;
    logic              r_fired, n_fired;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [WORD_W-1:0] r_cmp, n_cmp;
    logic              r_irq, n_irq;
    logic [WORD_W-1:0] r_preempt;

    logic              r_strobe, n_strobe;
    logic [ID_W-1:0]   r_o_id, n_o_id;
    logic              r_o_valid, n_o_valid;
    logic              r_o_pre, n_o_pre;
    logic [1:0]        r_o_status, n_o_status;
    logic [WORD_W-1:0] r_o_wake, n_o_wake;
    logic [WORD_W-1:0] r_o_cmp, n_o_cmp;
    logic              r_o_irq, n_o_irq;
    logic              r_o_yield, n_o_yield;
    logic              r_o_last, n_o_last;

    t_unit_op          unit_op;
    logic [WORD_W-1:0] unit_a, unit_b, unit_res;
    logic              unit_carry;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    t_entry            mem_wdata, mem_rdata, new_entry;

    saq_unit u_unit (
        .i_op     (unit_op),
        .i_a      (unit_a),
        .i_b      (unit_b),
        .o_result (unit_res),
        .o_carry  (unit_carry)
    );

    saq_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign new_entry.wake = r_wake;
    assign new_entry.id   = (r_kind == KIND_PREEMPT) ? '0 : r_id;
    assign new_entry.pre  = (r_kind == KIND_PREEMPT);

    // Operand select for the shared adder
    always_comb begin
        unit_op = OP_ADD;
        unit_a  = '0;
        unit_b  = '0;
        unique case (r_state)
            S_WAKE: begin
                unit_op = OP_ADD;
                unit_a  = (r_kind == KIND_SLEEP) ? r_base : r_now;
                unit_b  = (r_kind == KIND_SLEEP) ? r_cnt : r_preempt;
            end
            S_PAST: begin
                unit_op = OP_SUB;
                unit_a  = r_wake;
                unit_b  = r_now;
            end
            S_ICMP: begin
                unit_op = OP_SUB;
                unit_a  = mem_rdata.wake;
                unit_b  = r_wake;
            end
            S_ECMP: begin
                unit_op = OP_SUB;
                unit_a  = r_now;
                unit_b  = mem_rdata.wake;
            end
            default: begin
                unit_op = OP_ADD;
            end
        endcase
    end

    always_comb begin
        logic last_one;
        n_state    = r_state;
        n_kind     = r_kind;
        n_id       = r_id;
        n_base     = r_base;
        n_cnt      = r_cnt;
        n_now      = r_now;
        n_user     = r_user;
        n_wake     = r_wake;
        n_i        = r_i;
        n_n        = r_n;
        n_fired    = r_fired;
        n_head     = r_head;
        n_count    = r_count;
        n_cmp      = r_cmp;
        n_irq      = r_irq;
        n_strobe   = 1'b0;
        n_o_id     = '0;
        n_o_valid  = 1'b0;
        n_o_pre    = 1'b0;
        n_o_status = ST_OK;
        n_o_wake   = '0;
        n_o_cmp    = r_cmp;
        n_o_irq    = r_irq;
        n_o_yield  = 1'b0;
        n_o_last   = 1'b1;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = new_entry;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        last_one   = (CW'(r_i + 1'b1) == r_n);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind  = i_kind;
                    n_id    = i_alarm_id;
                    n_base  = i_base_time;
                    n_cnt   = i_tick_count;
                    n_now   = i_now;
                    n_user  = i_from_user_mode;
                    n_i     = '0;
                    n_fired = 1'b0;
                    unique case (i_kind)
                        KIND_SLEEP, KIND_PREEMPT: begin
                            n_state = S_WAKE;
                        end
                        KIND_EVENT: begin
                            n_state = S_ERD;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_WAKE: begin
                n_wake  = unit_res;
                n_state = S_PAST;
            end
            S_PAST: begin
                if (!unit_carry) begin
                    n_strobe   = 1'b1;
                    n_o_status = ST_PAST;
                    n_o_wake   = r_wake;
                    n_state    = S_IDLE;
                end else if (r_count == CW'(QUEUE_DEPTH)) begin
                    n_strobe   = 1'b1;
                    n_o_status = ST_FULL;
                    n_o_wake   = r_wake;
                    n_state    = S_IDLE;
                end else begin
                    n_i     = r_count;
                    n_state = S_IRD;
                end
            end
            S_IRD: begin
                if (r_i == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_head;
                    n_count   = CW'(r_count + 1'b1);
                    n_cmp     = r_wake;
                    n_irq     = 1'b1;
                    n_strobe  = 1'b1;
                    n_o_wake  = r_wake;
                    n_o_cmp   = r_wake;
                    n_o_irq   = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = phys(r_head, CW'(r_i - 1'b1));
                    n_state   = S_ICMP;
                end
            end
            S_ICMP: begin
                mem_we    = 1'b1;
                mem_waddr = phys(r_head, r_i);
                if (unit_carry) begin
                    // shift the equal or later entry one place back
                    mem_wdata = mem_rdata;
                    n_i       = CW'(r_i - 1'b1);
                    n_state   = S_IRD;
                end else begin
                    n_count  = CW'(r_count + 1'b1);
                    n_irq    = 1'b1;
                    n_strobe = 1'b1;
                    n_o_wake = r_wake;
                    n_o_irq  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_ERD: begin
                if (r_i == r_count) begin
                    n_irq = 1'b0;
                    n_n   = r_i;
                    n_i   = '0;
                    if (r_i == '0) begin
                        n_strobe  = 1'b1;
                        n_o_irq   = 1'b0;
                        n_o_yield = r_fired & r_user;
                        n_state   = S_IDLE;
                    end else begin
                        n_state = S_PRD;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = phys(r_head, r_i);
                    n_state   = S_ECMP;
                end
            end
            S_ECMP: begin
                if (unit_carry) begin
                    n_fired = r_fired | mem_rdata.pre;
                    n_i     = CW'(r_i + 1'b1);
                    n_state = S_ERD;
                end else begin
                    n_cmp = mem_rdata.wake;
                    n_n   = r_i;
                    n_i   = '0;
                    if (r_i == '0) begin
                        n_strobe  = 1'b1;
                        n_o_cmp   = mem_rdata.wake;
                        n_o_yield = r_fired & r_user;
                        n_state   = S_IDLE;
                    end else begin
                        n_state = S_PRD;
                    end
                end
            end
            S_PRD: begin
                mem_re    = 1'b1;
                mem_raddr = phys(r_head, r_i);
                n_state   = S_PEMIT;
            end
            S_PEMIT: begin
                n_strobe  = 1'b1;
                n_o_id    = mem_rdata.pre ? '0 : mem_rdata.id;
                n_o_valid = 1'b1;
                n_o_pre   = mem_rdata.pre;
                n_o_wake  = mem_rdata.wake;
                n_o_yield = last_one & r_fired & r_user;
                n_o_last  = last_one;
                if (last_one) begin
                    // drop the expired entries
                    n_head  = phys(r_head, r_n);
                    n_count = CW'(r_count - r_n);
                    n_state = S_IDLE;
                end else begin
                    n_i     = CW'(r_i + 1'b1);
                    n_state = S_PRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_cmp     <= '1;
            r_irq     <= 1'b0;
            r_preempt <= PREEMPT_TICKS_RST;
            r_strobe  <= 1'b0;
            r_i       <= '0;
            r_n       <= '0;
            r_fired   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_cmp    <= n_cmp;
            r_irq    <= n_irq;
            r_strobe <= n_strobe;
            r_i      <= n_i;
            r_n      <= n_n;
            r_fired  <= n_fired;
            if (i_cfg_we) begin
                r_preempt <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_id       <= n_id;
        r_base     <= n_base;
        r_cnt      <= n_cnt;
        r_now      <= n_now;
        r_user     <= n_user;
        r_wake     <= n_wake;
        r_o_id     <= n_o_id;
        r_o_valid  <= n_o_valid;
        r_o_pre    <= n_o_pre;
        r_o_status <= n_o_status;
        r_o_wake   <= n_o_wake;
        r_o_cmp    <= n_o_cmp;
        r_o_irq    <= n_o_irq;
        r_o_yield  <= n_o_yield;
        r_o_last   <= n_o_last;
    end

    assign busy               = (r_state != S_IDLE);
    assign o_strobe           = r_strobe;
    assign o_expired_id       = r_o_id;
    assign o_expired_valid    = r_o_valid;
    assign o_expired_preempt  = r_o_pre;
    assign o_status           = r_o_status;
    assign o_wake_time        = r_o_wake;
    assign o_compare_value    = r_o_cmp;
    assign o_timer_irq_enable = r_o_irq;
    assign o_yield_request    = r_o_yield;
    assign o_last             = r_o_last;

    `SAQ_AST_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(QUEUE_DEPTH))
    `SAQ_AST_IMP(a_irq_when_queued, i_clk, i_rst_n, (r_state == S_IDLE) && (r_count != '0), r_irq)
    `SAQ_AST_IMP(a_more_words_busy, i_clk, i_rst_n, o_strobe && !o_last, busy)
    `SAQ_AST_NEXT(a_accept_reacts, i_clk, i_rst_n, start && !busy, busy || o_strobe)

endmodule
